// ===== rtl/nrfs_pkg.sv =====
// Shared types, codes and constants for the NMEA RMC field splitter.
package nrfs_pkg;

    localparam int POS_W   = 7;
    localparam int FIELD_W = 4;
    localparam int CNT_W   = 7;
    localparam int BYTE_W  = 8;
    localparam int TAG_W   = 40;

    localparam logic [TAG_W-1:0]   TAG_RESET       = 40'h47_50_52_4D_43; // "GPRMC"
    localparam logic [BYTE_W-1:0]  ASCII_COMMA     = 8'h2C;
    localparam logic [BYTE_W-1:0]  ASCII_STAR      = 8'h2A;
    localparam logic [POS_W-1:0]   TAG_FIRST_POS   = 7'd1;
    localparam logic [POS_W-1:0]   TAG_LAST_POS    = 7'd5;
    localparam logic [POS_W-1:0]   FIRST_FIELD_POS = 7'd7;
    localparam logic [FIELD_W-1:0] LAST_FIELD_NO   = 4'd10;

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_CHAR   = 2'd1,
        KIND_END    = 2'd2,
        KIND_REJECT = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_HEADER = 2'd1,
        PH_FIELDS = 2'd2
    } phase_t;

    typedef struct packed {
        kind_t              kind;
        logic [FIELD_W-1:0] field_index;
        logic [CNT_W-1:0]   char_pos;
        logic [BYTE_W-1:0]  char_value;
        logic [CNT_W-1:0]   field_length;
        logic               last_field;
    } result_t;

    // Expected tag letter for header positions one to five; first letter in the top byte.
    function automatic logic [BYTE_W-1:0] tag_letter(input logic [TAG_W-1:0] tag,
                                                     input logic [POS_W-1:0] pos);
        logic [BYTE_W-1:0] letter;
        begin
            unique case (pos)
                7'd1:    letter = tag[39:32];
                7'd2:    letter = tag[31:24];
                7'd3:    letter = tag[23:16];
                7'd4:    letter = tag[15:8];
                7'd5:    letter = tag[7:0];
                default: letter = '0;
            endcase
            return letter;
        end
    endfunction

endpackage

// ===== rtl/nrfs_parse.sv =====
// Parser state machine: header check, field split, one result per consumed byte.
module nrfs_parse
    import nrfs_pkg::*;
#(
    parameter int MAX_SENTENCE = 80
)(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    consume,
    input  logic [BYTE_W-1:0]       rx_byte,
    input  logic                    sentence_start,
    input  logic [TAG_W-1:0]        sentence_tag,
    output result_t                 result
);

    localparam logic [POS_W-1:0] LIMIT_POS = POS_W'(MAX_SENTENCE - 1);

    phase_t             phase_reg, phase_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic               match_reg, match_next;
    logic [FIELD_W-1:0] field_reg, field_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    logic [POS_W-1:0]   pos_inc;
    logic               match_eff;
    logic               finishing;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            pos_reg   <= '0;
            match_reg <= 1'b1;
            field_reg <= '0;
            cnt_reg   <= '0;
        end
        else if (consume)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            match_reg <= match_next;
            field_reg <= field_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        match_next = match_reg;
        field_next = field_reg;
        cnt_next   = cnt_reg;
        result     = '0;
        pos_inc    = pos_reg + 1'b1;
        match_eff  = match_reg && (tag_letter(sentence_tag, pos_inc) == rx_byte);
        finishing  = (field_reg >= LAST_FIELD_NO) && (rx_byte == ASCII_STAR);

        if (sentence_start)
        begin
            phase_next = PH_HEADER;
            pos_next   = '0;
            match_next = 1'b1;
            field_next = '0;
            cnt_next   = '0;
        end
        else
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    pos_next = pos_inc;
                    if (pos_inc >= TAG_FIRST_POS && pos_inc <= TAG_LAST_POS)
                    begin
                        match_next = match_eff;
                        if (pos_inc == TAG_LAST_POS && !match_eff)
                        begin
                            result.kind = KIND_REJECT;
                            phase_next  = PH_IDLE;
                        end
                    end
                    else if (pos_inc >= FIRST_FIELD_POS - 1'b1)
                    begin
                        phase_next = PH_FIELDS;
                    end
                end
                PH_FIELDS:
                begin
                    pos_next = pos_inc;
                    priority if (!finishing && pos_inc >= LIMIT_POS)
                    begin
                        result.kind = KIND_REJECT;
                        phase_next  = PH_IDLE;
                    end
                    else if (finishing)
                    begin
                        result.kind         = KIND_END;
                        result.field_index  = field_reg;
                        result.field_length = cnt_reg;
                        result.last_field   = 1'b1;
                        phase_next          = PH_IDLE;
                    end
                    else if (field_reg < LAST_FIELD_NO && rx_byte == ASCII_COMMA)
                    begin
                        result.kind         = KIND_END;
                        result.field_index  = field_reg;
                        result.field_length = cnt_reg;
                        field_next          = field_reg + 1'b1;
                        cnt_next            = '0;
                    end
                    else
                    begin
                        result.kind        = KIND_CHAR;
                        result.field_index = field_reg;
                        result.char_pos    = cnt_reg;
                        result.char_value  = rx_byte;
                        cnt_next           = cnt_reg + 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    a_field_range: assert property (@(posedge clk) disable iff (!rst_n)
        field_reg <= LAST_FIELD_NO)
        else $error("field number past last field");

    a_header_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_HEADER) |-> (pos_reg < FIRST_FIELD_POS))
        else $error("header phase beyond tag comma");

endmodule

// ===== rtl/nrfs_out_fifo.sv =====
// Two-entry result buffer between the parser and the output stream.
module nrfs_out_fifo
    import nrfs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  result_t in_word,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_word
);

    result_t    mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_word  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'd2)
        else $error("result buffer overflow");

endmodule

// ===== rtl/nmea_rmc_field_splitter.sv =====
// Top level of the NMEA RMC field splitter: stream ports, tag register, input stage.
//
// Takes one byte of an NMEA sentence per word and answers each byte with exactly one
// result word. A byte with s_tuser set opens a sentence (position zero) and may arrive
// at any time, also mid-sentence. Positions one to five are checked against the tag
// register; a mismatch gives a reject word at position five. Position six is skipped,
// then bytes are split into eleven fields: fields zero to nine end at a comma, field
// ten ends at an asterisk (m_tlast set on that field-end word). Every field character
// gives a character word, every field end a field-end word with the character count.
// A sentence that reaches byte MAX_SENTENCE-1 without its final asterisk is rejected.
// Throughput is one byte per clock while the result buffer has room. A byte sits in the
// input register after its accepting edge, and its result is written into the result
// buffer once that buffer has room, from where the master side can take it. The
// two-entry result buffer absorbs a master-side stall; once it is full, s_tready drops
// until a word leaves, so in steady streaming the slave side is held back after such
// a stall as well.
// Write the tag only while the block is idle.
module nmea_rmc_field_splitter
    import nrfs_pkg::*;
#(
    parameter int MAX_SENTENCE = 80    // buffer limit, 16..127
)(
    input  logic        clk,
    input  logic        rst_n,
    // tag register write
    input  logic        cfg_wr_en,
    input  logic [39:0] cfg_wr_data,   // sentence_tag, first letter in [39:32]
    // byte stream in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // [7:0] rx_byte
    input  logic        s_tuser,       // [0] sentence_start
    // result stream out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,       // [3:0] field_index, [10:4] char_pos,
                                       // [18:11] char_value, [25:19] field_length, rest 0
    output logic [1:0]  m_tuser,       // [1:0] kind
    output logic        m_tlast        // last_field
);

    logic [TAG_W-1:0]  tag_reg;

    // input stage
    logic              in_vld_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_start_reg;

    logic              res_ready;
    logic              advance;
    result_t           res_word;
    result_t           out_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= TAG_RESET;
        end
        else if (cfg_wr_en)
        begin
            tag_reg <= cfg_wr_data;
        end
    end

    // The input word moves on whenever the buffer has room for its result.
    assign advance  = in_vld_reg && res_ready;
    assign s_tready = !in_vld_reg || res_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg  <= s_tdata;
            in_start_reg <= s_tuser;
        end
    end

    nrfs_parse #(
        .MAX_SENTENCE (MAX_SENTENCE)
    ) u_parse (
        .clk            (clk),
        .rst_n          (rst_n),
        .consume        (advance),
        .rx_byte        (in_byte_reg),
        .sentence_start (in_start_reg),
        .sentence_tag   (tag_reg),
        .result         (res_word)
    );

    nrfs_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_vld_reg),
        .in_ready  (res_ready),
        .in_word   (res_word),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_word  (out_word)
    );

    assign m_tdata = {6'b0, out_word.field_length, out_word.char_value,
                      out_word.char_pos, out_word.field_index};
    assign m_tuser = out_word.kind;
    assign m_tlast = out_word.last_field;

    // an empty input stage always takes a word
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_vld_reg |-> s_tready)
        else $error("input stage empty but not ready");

endmodule

// ===== verif/tb_nmea_rmc_field_splitter.sv =====
// Self-checking testbench for the NMEA RMC field splitter.
module tb_nmea_rmc_field_splitter;
    import nrfs_pkg::*;

    localparam int SENT_LIMIT  = 80;    // buffer limit handed to the block
    localparam int TAIL_CYCLES = 8;     // quiet cycles after the last word
    localparam int MAX_REPORTS = 10;
    localparam int HOLD_OFF    = 60;    // long receiver stall, in cycles

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               cfg_wr_en   = 1'b0;
    logic [TAG_W-1:0]   cfg_wr_data = '0;
    logic               s_tvalid    = 1'b0;
    logic               s_tready;
    logic [BYTE_W-1:0]  s_tdata     = '0;
    logic               s_tuser     = 1'b0;
    logic               m_tvalid;
    logic               m_tready    = 1'b0;
    logic [31:0]        m_tdata;
    logic [1:0]         m_tuser;
    logic               m_tlast;

    // Shadow of the splitter: tag register plus sentence tracking state.
    logic [TAG_W-1:0]   tag_reg;
    logic [POS_W-1:0]   pos_q;
    phase_t             phase_q;
    logic               hdr_ok_q;
    logic [FIELD_W-1:0] field_q;
    logic [CNT_W-1:0]   nchars_q;

    result_t expected_words[$];

    int fail_count      = 0;
    int words_sent      = 0;
    int words_checked   = 0;
    int rmc_words       = 0;
    int sentences_done  = 0;
    int rejects_seen    = 0;
    int burst_left      = 0;
    int hold_off_cycles = 0;

    nmea_rmc_field_splitter #(
        .MAX_SENTENCE(SENT_LIMIT)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Next result word for one accepted byte; advances the shadow state.
    function automatic result_t predict_word(input logic [BYTE_W-1:0] b, input logic start);
        result_t r;
        logic    finishing;
        r = '0;
        if (start)
        begin
            // start byte restarts from any phase and yields no event
            pos_q    = '0;
            phase_q  = PH_HEADER;
            hdr_ok_q = 1'b1;
            field_q  = '0;
            nchars_q = '0;
            return r;
        end
        if (phase_q == PH_HEADER)
        begin
            pos_q = pos_q + 1'b1;
            if (pos_q >= TAG_FIRST_POS && pos_q <= TAG_LAST_POS)
            begin
                if (tag_reg[8 * (TAG_LAST_POS - pos_q) +: 8] != b)
                    hdr_ok_q = 1'b0;
                if (pos_q == TAG_LAST_POS && !hdr_ok_q)
                begin
                    r.kind  = KIND_REJECT;
                    phase_q = PH_IDLE;
                end
            end
            else if (int'(pos_q) + 1 >= int'(FIRST_FIELD_POS))
                phase_q = PH_FIELDS;   // comma after the tag is skipped
        end
        else if (phase_q == PH_FIELDS)
        begin
            pos_q     = pos_q + 1'b1;
            finishing = (field_q >= LAST_FIELD_NO) && (b == ASCII_STAR);
            if (!finishing && int'(pos_q) + 1 >= SENT_LIMIT)
            begin
                // out of buffer before the closing asterisk
                r.kind  = KIND_REJECT;
                phase_q = PH_IDLE;
            end
            else if (finishing)
            begin
                r.kind         = KIND_END;
                r.field_index  = field_q;
                r.field_length = nchars_q;
                r.last_field   = 1'b1;
                phase_q        = PH_IDLE;
            end
            else if (field_q < LAST_FIELD_NO && b == ASCII_COMMA)
            begin
                r.kind         = KIND_END;
                r.field_index  = field_q;
                r.field_length = nchars_q;
                field_q        = field_q + 1'b1;
                nchars_q       = '0;
            end
            else
            begin
                // also covers an asterisk before field ten and a comma inside it
                r.kind        = KIND_CHAR;
                r.field_index = field_q;
                r.char_pos    = nchars_q;
                r.char_value  = b;
                nchars_q      = nchars_q + 1'b1;
            end
        end
        return r;
    endfunction

    // Offer one byte, in bursts with random gaps; returns at the falling edge after acceptance.
    task automatic send_word(input logic [BYTE_W-1:0] b, input logic start);
        if (burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            repeat (($urandom_range(0, 3) == 0) ? $urandom_range(5, 15) : $urandom_range(1, 3))
                @(negedge clk);
            // now and then a long burst with no gaps at all
            burst_left = ($urandom_range(0, 7) == 0) ? 120 : $urandom_range(1, 12);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= start;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_words.push_back(predict_word(b, start));
        words_sent++;
        burst_left--;
        @(negedge clk);
    endtask

    // Stop offering and let every expected word come out.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (expected_words.size() != 0)
            @(negedge clk);
    endtask

    // Tag write; the caller makes sure the sentence logic sits idle.
    task automatic write_tag(input logic [TAG_W-1:0] value);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        tag_reg     = value;
    endtask

    // One sentence with the current tag: random field content, optionally a broken
    // tag letter, long fields, or cut short after cut_after bytes.
    task automatic send_rmc(input bit bad_tag, input bit stretch, input int cut_after);
        logic [BYTE_W-1:0] line[$];
        logic [BYTE_W-1:0] c;
        int                len;
        int                bad_at;
        if ($urandom_range(0, 3) == 0)
            line.push_back(8'($urandom));
        else
            line.push_back("$");
        bad_at = $urandom_range(1, 5);
        for (int k = 1; k <= 5; k++)
        begin
            c = tag_reg[8 * (5 - k) +: 8];
            if (bad_tag && k == bad_at)
                c = c ^ 8'($urandom_range(1, 255));
            line.push_back(c);
        end
        line.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom) : ASCII_COMMA);
        for (int f = 0; f <= LAST_FIELD_NO; f++)
        begin
            len = stretch ? $urandom_range(1, 10) : $urandom_range(0, 4);
            for (int k = 0; k < len; k++)
            begin
                c = 8'($urandom);
                if ($urandom_range(0, 15) == 0)
                    c = (f < LAST_FIELD_NO) ? ASCII_STAR : ASCII_COMMA;
                else if (f < LAST_FIELD_NO && c == ASCII_COMMA)
                    c = "0";
                else if (f == LAST_FIELD_NO && c == ASCII_STAR)
                    c = "0";
                line.push_back(c);
            end
            line.push_back((f < LAST_FIELD_NO) ? ASCII_COMMA : ASCII_STAR);
        end
        while (cut_after > 0 && line.size() > cut_after)
            void'(line.pop_back());
        foreach (line[i])
            send_word(line[i], i == 0);
        rmc_words += line.size();
    endtask

    // Idle bytes, an aborted header, then a header with a wrong last letter.
    task automatic test_idle_and_reject();
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'hFF, 1'b1);        // start byte value is don't-care
        send_word("G", 1'b0);
        send_word("$", 1'b1);          // restart mid-header
        send_word("G", 1'b0);
        send_word("P", 1'b0);
        send_word("R", 1'b0);
        send_word("M", 1'b0);
        send_word("D", 1'b0);          // reject at position five
        send_word(ASCII_COMMA, 1'b0);  // ignored while idle
    endtask

    // Shortest useful sentence: separators in the wrong field and byte extremes as data.
    task automatic test_short_sentence();
        send_word("$", 1'b1);
        for (int k = 1; k <= 5; k++)
            send_word(tag_reg[8 * (5 - k) +: 8], 1'b0);
        send_word(ASCII_COMMA, 1'b0);
        send_word(ASCII_STAR, 1'b0);   // plain data in field zero
        send_word(ASCII_COMMA, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        repeat (9)
            send_word(ASCII_COMMA, 1'b0);
        send_word(ASCII_COMMA, 1'b0);  // plain data in field ten
        send_word(ASCII_STAR, 1'b0);
    endtask

    // Per tag: one full sentence, then a broken header cut a little after the reject.
    task automatic test_tag_settings();
        logic [TAG_W-1:0] tags[4];
        tags[0] = '0;
        tags[1] = '1;
        tags[2] = 40'h47_4E_52_4D_43;
        tags[3] = {8'($urandom), 32'($urandom)};
        foreach (tags[i])
        begin
            write_tag(tags[i]);
            send_rmc(1'b0, 1'b0, 0);
            send_rmc(1'b1, 1'b0, 8);
        end
        write_tag(TAG_RESET);
    endtask

    // Long fields land on both sides of the buffer limit.
    task automatic test_buffer_limit();
        repeat (2)
            send_rmc(1'b0, 1'b1, 0);
    endtask

    // Receiver holds off while the sender keeps offering, so the input side stalls.
    task automatic test_output_stall();
        hold_off_cycles = HOLD_OFF;
        burst_left      = 200;
        send_rmc(1'b0, 1'b0, 0);
    endtask

    task automatic test_random_traffic();
        int first_word;
        int last_cfg;
        int pick;
        first_word = rmc_words;
        last_cfg   = rmc_words;
        while (rmc_words - first_word < 80)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 65)
                send_rmc(1'b0, $urandom_range(0, 9) == 0, 0);
            else if (pick < 78)
                send_rmc(1'b1, 1'b0, 0);
            else if (pick < 90)
                send_rmc(1'b0, 1'b0, $urandom_range(1, 30));   // next start cuts in
            else
                repeat ($urandom_range(1, 6))
                    send_word(8'($urandom), 1'b0);
            // retag only between sentences
            if (rmc_words - last_cfg > 40 && phase_q == PH_IDLE)
            begin
                write_tag(($urandom_range(0, 2) == 0) ? TAG_RESET
                                                      : {8'($urandom), 32'($urandom)});
                last_cfg = rmc_words;
            end
        end
    endtask

    // Receiver: random stall density per window, plus the requested long hold-off.
    initial
    begin : result_sink
        int stall_pct;
        int window_left;
        stall_pct   = 0;
        window_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off_cycles > 0)
            begin
                m_tready <= 1'b0;
                hold_off_cycles--;
            end
            else
            begin
                if (window_left == 0)
                begin
                    case ($urandom_range(0, 4))
                        0, 1:    stall_pct = 0;
                        2:       stall_pct = 30;
                        3:       stall_pct = 60;
                        default: stall_pct = 90;
                    endcase
                    window_left = $urandom_range(16, 64);
                end
                window_left--;
                m_tready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // Compare each result word against the oldest expectation.
    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_words.size() == 0)
            begin
                if (fail_count < MAX_REPORTS)
                    $display("unexpected result word: kind %0d tdata %08h last %0b",
                             m_tuser, m_tdata, m_tlast);
                fail_count++;
            end
            else
            begin
                want = expected_words.pop_front();
                words_checked++;
                if (want.kind == KIND_REJECT)
                    rejects_seen++;
                if (want.kind == KIND_END && want.last_field)
                    sentences_done++;
                if (m_tuser != want.kind || m_tdata[3:0] != want.field_index ||
                    m_tdata[10:4] != want.char_pos || m_tdata[18:11] != want.char_value ||
                    m_tdata[25:19] != want.field_length || m_tdata[31:26] != '0 ||
                    m_tlast != want.last_field)
                begin
                    if (fail_count < MAX_REPORTS)
                        $display({"mismatch at word %0d: expected kind %0d field %0d pos %0d ",
                                  "char %02h len %0d last %0b; got kind %0d field %0d pos %0d ",
                                  "char %02h len %0d last %0b pad %02h"},
                                 words_checked, want.kind, want.field_index, want.char_pos,
                                 want.char_value, want.field_length, want.last_field,
                                 m_tuser, m_tdata[3:0], m_tdata[10:4], m_tdata[18:11],
                                 m_tdata[25:19], m_tlast, m_tdata[31:26]);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin : test_sequence
        tag_reg  = TAG_RESET;
        pos_q    = '0;
        phase_q  = PH_IDLE;
        hdr_ok_q = 1'b1;
        field_q  = '0;
        nchars_q = '0;
        repeat (9)
            @(negedge clk);
        rst_n <= 1'b1;

        test_idle_and_reject();
        test_short_sentence();
        test_tag_settings();
        test_buffer_limit();
        test_output_stall();
        test_random_traffic();

        wait_drained();
        repeat (TAIL_CYCLES)
            @(negedge clk);

        $display("tb: %0d bytes in, %0d words checked, %0d sentences closed, %0d rejected",
                 words_sent, words_checked, sentences_done, rejects_seen);
        $display("tb: tags tried: zeros, ones, reset value and random; one long output stall");
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/nrfs_pkg.sv
rtl/nrfs_parse.sv
rtl/nrfs_out_fifo.sv
rtl/nmea_rmc_field_splitter.sv
verif/tb_nmea_rmc_field_splitter.sv
